// File: sv/heat_stencil_residual_core_macros.svh
// Assertion macros for the heat stencil residual core.
`ifndef HEAT_STENCIL_RESIDUAL_CORE_MACROS_SVH
`define HEAT_STENCIL_RESIDUAL_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define HSR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("heat stencil residual core: assertion failed");
`define HSR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) \
      else $error("heat stencil residual core: assertion failed");
`else
`define HSR_ASSERT(lbl, clk, rst, prop)
`define HSR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: sv/hsr_pkg.sv
package hsr_pkg;

   localparam int VALUE_WIDTH    = 32;
   localparam int RESIDUAL_WIDTH = 56;
   localparam int POS_WIDTH      = 8;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 9;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GRID_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GRID_HEIGHT = 1'd1;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int GRID_RESET     = 10;
   localparam int MIN_DIM        = 3;

endpackage

// File: sv/hsr_if.sv
interface hsr_req_if;
   import hsr_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] u_value;
   logic signed [VALUE_WIDTH-1:0] udot_value;

   modport source (output valid, output u_value, output udot_value, input ready);
   modport sink   (input valid, input u_value, input udot_value, output ready);
endinterface

interface hsr_rsp_if;
   import hsr_pkg::*;

   logic                             valid;
   logic                             ready;
   logic signed [RESIDUAL_WIDTH-1:0] residual;
   logic [POS_WIDTH-1:0]             out_row;
   logic [POS_WIDTH-1:0]             out_col;
   logic                             last_of_run;

   modport source (output valid, output residual, output out_row, output out_col,
                   output last_of_run, input ready);
   modport sink   (input valid, input residual, input out_row, input out_col,
                   input last_of_run, output ready);
endinterface

// File: sv/heat_stencil_residual_core.sv
// Channel   Direction  Carries
// req_bus   in         u_value, udot_value of one grid point, raster order
// rsp_bus   out        residual, out_row, out_col, last_of_run
// csr_*     in         grid_width (index 0), grid_height (index 1)
//
// One point is taken per cycle when the pipeline is not held; on the last grid row each point gives
// two results through the single output register, so the next point is not taken until the second has entered it.
// A result passes in order through the memory read, the stencil sums and the multipliers, then the
// final add into the output register.
// Reset is synchronous; the line memory is not cleared and needs no pass after reset.
// A stalled output holds the whole pipeline; req_bus.ready falls only once the last stage is full.
`include "heat_stencil_residual_core_macros.svh"

module heat_stencil_residual_core #(
   parameter int MAX_WIDTH  = hsr_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = hsr_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   hsr_req_if.sink                             req_bus,
   hsr_rsp_if.source                           rsp_bus,
   input  logic                                csr_we,
   input  logic [hsr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [hsr_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import hsr_pkg::*;

   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int RW      = $clog2(MAX_HEIGHT);
   localparam int SXW     = 2 * CW;
   localparam int SYW     = 2 * RW;
   localparam int DW      = VALUE_WIDTH + 3;
   localparam int PXW     = DW + SXW + 1;
   localparam int PYW     = DW + SYW + 1;
   localparam int DIFFW   = ((PXW > PYW) ? PXW : PYW) + 2;
   localparam int RESET_W = (GRID_RESET > MAX_WIDTH) ? MAX_WIDTH : GRID_RESET;
   localparam int RESET_H = (GRID_RESET > MAX_HEIGHT) ? MAX_HEIGHT : GRID_RESET;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] older;
      logic signed [VALUE_WIDTH-1:0] prior;
      logic signed [VALUE_WIDTH-1:0] udot;
   } line_type;

   function automatic int clamp_dim(input logic [CSR_DATA_WIDTH-1:0] v, input int maxv);
      int vi;
      vi = int'(v);
      if (vi < MIN_DIM) return MIN_DIM;
      if (vi > maxv) return maxv;
      return vi;
   endfunction

   // Grid size registers, kept as (size - 1) and its square.
   logic [CW-1:0]  wm1_ff, wm1_in;
   logic [RW-1:0]  hm1_ff, hm1_in;
   logic [SXW-1:0] sx_ff, sx_in, wm1_wide;
   logic [SYW-1:0] sy_ff, sy_in, hm1_wide;
   logic           csr_hit;

   assign wm1_in   = CW'(clamp_dim(csr_wdata, MAX_WIDTH) - 1);
   assign hm1_in   = RW'(clamp_dim(csr_wdata, MAX_HEIGHT) - 1);
   assign wm1_wide = SXW'(wm1_in);
   assign hm1_wide = SYW'(hm1_in);
   assign sx_in    = wm1_wide * wm1_wide;
   assign sy_in    = hm1_wide * hm1_wide;
   assign csr_hit  = csr_we && (csr_index == CSR_GRID_WIDTH || csr_index == CSR_GRID_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         wm1_ff <= CW'(RESET_W - 1);
         hm1_ff <= RW'(RESET_H - 1);
         sx_ff  <= SXW'((RESET_W - 1) * (RESET_W - 1));
         sy_ff  <= SYW'((RESET_H - 1) * (RESET_H - 1));
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_WIDTH: begin
               wm1_ff <= wm1_in;
               sx_ff  <= sx_in;
            end
            CSR_GRID_HEIGHT: begin
               hm1_ff <= hm1_in;
               sy_ff  <= sy_in;
            end
            default: begin
            end
         endcase
      end
   end

   // Pipeline control.
   logic adv;
   logic accept;

   assign accept        = req_bus.valid && adv;
   assign req_bus.ready = adv;

   // Position counters.
   logic [CW-1:0] col_ff, col_in, col_nxt;
   logic [RW-1:0] row_ff, row_in;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == wm1_ff) begin
            col_in = '0;
            row_in = (row_ff == hm1_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col_nxt = (col_ff == CW'(MAX_WIDTH - 1)) ? '0 : col_ff + 1'b1;

   // Stage 1: line memory data arrives.
   logic                          s1_v_ff;
   logic signed [VALUE_WIDTH-1:0] s1_u_ff, s1_ud_ff;
   logic [CW-1:0]                 s1_col_ff;
   logic [RW-1:0]                 s1_row_ff;
   logic                          s1_has_first_ff, s1_last_row_ff, s1_boundary_ff;

   line_type                      line_mem [MAX_WIDTH];
   line_type                      rd_cur_ff, rd_nxt_ff, wr_word;
   logic                          mem_we;
   logic signed [VALUE_WIDTH-1:0] left_ff;
   logic signed [DW-1:0]          s1_uxx, s1_uyy, s1_center2;

   assign mem_we        = adv && s1_v_ff;
   assign wr_word.older = rd_cur_ff.prior;
   assign wr_word.prior = s1_u_ff;
   assign wr_word.udot  = s1_ud_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[s1_col_ff] <= wr_word;
      end
      if (accept) begin
         rd_cur_ff <= line_mem[col_ff];
         rd_nxt_ff <= line_mem[col_nxt];
      end
   end

   // The left neighbor is the center of the point just before in the same row.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         left_ff <= rd_cur_ff.prior;
      end
   end

   assign s1_center2 = DW'(rd_cur_ff.prior) <<< 1;
   assign s1_uxx     = DW'(left_ff) + DW'(rd_nxt_ff.prior) - s1_center2;
   assign s1_uyy     = DW'(rd_cur_ff.older) + DW'(s1_u_ff) - s1_center2;

   // Stage 2: stencil differences. Stage 3: scaled by the squared grid sizes.
   logic                          s2_v_ff, s3_v_ff;
   logic signed [DW-1:0]          s2_uxx_ff, s2_uyy_ff;
   logic signed [VALUE_WIDTH-1:0] s2_udot_ff, s2_center_ff, s2_u_ff;
   logic signed [VALUE_WIDTH-1:0] s3_udot_ff, s3_center_ff, s3_u_ff;
   logic [CW-1:0]                 s2_col_ff, s3_col_ff;
   logic [RW-1:0]                 s2_row_ff, s3_row_ff;
   logic                          s2_has_first_ff, s2_last_row_ff, s2_boundary_ff;
   logic                          s3_has_first_ff, s3_last_row_ff, s3_boundary_ff;
   logic signed [PXW-1:0]         s3_pxx_ff, s3_pxx_in;
   logic signed [PYW-1:0]         s3_pyy_ff, s3_pyy_in;

   assign s3_pxx_in = PXW'(s2_uxx_ff) * PXW'($signed({1'b0, sx_ff}));
   assign s3_pyy_in = PYW'(s2_uyy_ff) * PYW'($signed({1'b0, sy_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= accept;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_u_ff         <= req_bus.u_value;
         s1_ud_ff        <= req_bus.udot_value;
         s1_col_ff       <= col_ff;
         s1_row_ff       <= row_ff;
         s1_has_first_ff <= (row_ff != '0);
         s1_last_row_ff  <= (row_ff == hm1_ff);
         s1_boundary_ff  <= (row_ff == RW'(1)) || (col_ff == '0) || (col_ff == wm1_ff);

         s2_uxx_ff       <= s1_uxx;
         s2_uyy_ff       <= s1_uyy;
         s2_udot_ff      <= rd_cur_ff.udot;
         s2_center_ff    <= rd_cur_ff.prior;
         s2_u_ff         <= s1_u_ff;
         s2_col_ff       <= s1_col_ff;
         s2_row_ff       <= s1_row_ff;
         s2_has_first_ff <= s1_has_first_ff;
         s2_last_row_ff  <= s1_last_row_ff;
         s2_boundary_ff  <= s1_boundary_ff;

         s3_pxx_ff       <= s3_pxx_in;
         s3_pyy_ff       <= s3_pyy_in;
         s3_udot_ff      <= s2_udot_ff;
         s3_center_ff    <= s2_center_ff;
         s3_u_ff         <= s2_u_ff;
         s3_col_ff       <= s2_col_ff;
         s3_row_ff       <= s2_row_ff;
         s3_has_first_ff <= s2_has_first_ff;
         s3_last_row_ff  <= s2_last_row_ff;
         s3_boundary_ff  <= s2_boundary_ff;
      end
   end

   // Emission: a point may give the result one row up, then its own boundary result.
   logic                             phase_ff, phase_in;
   logic                             slot_free, emit_first, emit_second, s3_final;
   logic signed [DIFFW-1:0]          s3_diff;
   logic signed [RESIDUAL_WIDTH-1:0] res_first;

   logic                             rsp_v_ff, rsp_v_in;
   logic signed [RESIDUAL_WIDTH-1:0] rsp_res_ff;
   logic [POS_WIDTH-1:0]             rsp_row_ff, rsp_col_ff;
   logic                             rsp_last_ff;

   assign s3_diff   = DIFFW'(s3_udot_ff) - (DIFFW'(s3_pxx_ff) + DIFFW'(s3_pyy_ff));
   assign res_first = s3_boundary_ff ? RESIDUAL_WIDTH'(s3_center_ff)
                                     : RESIDUAL_WIDTH'(s3_diff);

   assign slot_free   = !rsp_v_ff || rsp_bus.ready;
   assign emit_first  = s3_v_ff && s3_has_first_ff && !phase_ff;
   assign emit_second = s3_v_ff && s3_last_row_ff && (phase_ff || !s3_has_first_ff);
   assign s3_final    = emit_second || (emit_first && !s3_last_row_ff);
   assign adv         = !s3_v_ff || (!s3_has_first_ff && !s3_last_row_ff)
                        || (slot_free && s3_final);

   always_comb begin
      phase_in = phase_ff;
      if (adv) begin
         phase_in = 1'b0;
      end else if (slot_free && emit_first) begin
         phase_in = 1'b1;
      end
   end

   always_comb begin
      rsp_v_in = rsp_v_ff;
      if (slot_free && (emit_first || emit_second)) begin
         rsp_v_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free) begin
         if (emit_first) begin
            rsp_res_ff  <= res_first;
            rsp_row_ff  <= POS_WIDTH'(s3_row_ff - 1'b1);
            rsp_col_ff  <= POS_WIDTH'(s3_col_ff);
            rsp_last_ff <= !s3_last_row_ff;
         end else if (emit_second) begin
            rsp_res_ff  <= RESIDUAL_WIDTH'(s3_u_ff);
            rsp_row_ff  <= POS_WIDTH'(s3_row_ff);
            rsp_col_ff  <= POS_WIDTH'(s3_col_ff);
            rsp_last_ff <= 1'b1;
         end
      end
   end

   assign rsp_bus.valid       = rsp_v_ff;
   assign rsp_bus.residual    = rsp_res_ff;
   assign rsp_bus.out_row     = rsp_row_ff;
   assign rsp_bus.out_col     = rsp_col_ff;
   assign rsp_bus.last_of_run = rsp_last_ff;

   // The second emission phase is only reached by a last-row point that had a first result.
   `HSR_ASSERT(a_phase_ctx, clock, reset, phase_ff |-> (s3_v_ff && s3_has_first_ff && s3_last_row_ff))
   `HSR_ASSERT(a_pos_range, clock, reset, (col_ff <= wm1_ff) && (row_ff <= hm1_ff))
   `HSR_ASSERT(a_row0_not_last, clock, reset, (s3_v_ff && !s3_has_first_ff) |-> !s3_last_row_ff)
   `HSR_ASSERT_NEXT(a_csr_restart, clock, reset, csr_hit, (col_ff == '0) && (row_ff == '0))

endmodule

// File: dv/heat_stencil_residual_core_test.sv
`timescale 1ns / 1ps

class residual_scoreboard;
   typedef struct {
      logic signed [hsr_pkg::RESIDUAL_WIDTH-1:0] residual;
      logic [hsr_pkg::POS_WIDTH-1:0]             row;
      logic [hsr_pkg::POS_WIDTH-1:0]             col;
      logic                                      last_of_run;
   } residual_item_type;

   logic signed [31:0] older_u    [hsr_pkg::DEF_MAX_WIDTH];
   logic signed [31:0] prior_u    [hsr_pkg::DEF_MAX_WIDTH];
   logic signed [31:0] prior_udot [hsr_pkg::DEF_MAX_WIDTH];
   logic [hsr_pkg::CSR_DATA_WIDTH-1:0] grid_w;
   logic [hsr_pkg::CSR_DATA_WIDTH-1:0] grid_h;
   int unsigned col_pos;
   int unsigned row_pos;
   residual_item_type expected_residuals[$];
   int unsigned errors;

   function new();
      grid_w  = hsr_pkg::GRID_RESET[hsr_pkg::CSR_DATA_WIDTH-1:0];
      grid_h  = hsr_pkg::GRID_RESET[hsr_pkg::CSR_DATA_WIDTH-1:0];
      col_pos = 0;
      row_pos = 0;
      errors  = 0;
   endfunction

   function int unsigned pending();
      return expected_residuals.size();
   endfunction

   function int unsigned clamp_dim(logic [hsr_pkg::CSR_DATA_WIDTH-1:0] v, int unsigned maxv);
      if (v < hsr_pkg::MIN_DIM) return hsr_pkg::MIN_DIM;
      if (v > maxv) return maxv;
      return 32'(v);
   endfunction

   // Any register write restarts the grid at the origin; the line buffers keep their data.
   function void write_reg(logic [hsr_pkg::CSR_INDEX_WIDTH-1:0] index,
                           logic [hsr_pkg::CSR_DATA_WIDTH-1:0] value);
      if (index == hsr_pkg::CSR_GRID_WIDTH) grid_w = value;
      else if (index == hsr_pkg::CSR_GRID_HEIGHT) grid_h = value;
      col_pos = 0;
      row_pos = 0;
   endfunction

   function void push_residual(longint value, int unsigned r, int unsigned c, bit last_flag);
      residual_item_type item;
      item.residual    = value[hsr_pkg::RESIDUAL_WIDTH-1:0];
      item.row         = r[hsr_pkg::POS_WIDTH-1:0];
      item.col         = c[hsr_pkg::POS_WIDTH-1:0];
      item.last_of_run = last_flag;
      expected_residuals.push_back(item);
   endfunction

   function void note_point(logic signed [31:0] u_in, logic signed [31:0] udot_in);
      int unsigned w, h, c, r;
      longint center, res, sx, sy, uxx, uyy;
      bit bottom;
      w = clamp_dim(grid_w, hsr_pkg::DEF_MAX_WIDTH);
      h = clamp_dim(grid_h, hsr_pkg::DEF_MAX_HEIGHT);
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      bottom = (r == h - 1);

      // The point one row up is complete now that its lower neighbor has arrived.
      if (r >= 1) begin
         center = prior_u[c];
         if (r == 1 || c == 0 || c == w - 1) begin
            res = center;
         end else begin
            sx  = longint'(w - 1) * longint'(w - 1);
            sy  = longint'(h - 1) * longint'(h - 1);
            uxx = longint'(older_u[c - 1]) + longint'(prior_u[c + 1]) - 2 * center;
            uyy = longint'(older_u[c]) + longint'(u_in) - 2 * center;
            res = longint'(prior_udot[c]) - (uxx * sx + uyy * sy);
         end
         push_residual(res, r - 1, c, !bottom);
      end

      older_u[c]    = prior_u[c];
      prior_u[c]    = u_in;
      prior_udot[c] = udot_in;

      if (bottom) push_residual(longint'(u_in), r, c, 1'b1);

      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endfunction

   function void check_result(logic signed [hsr_pkg::RESIDUAL_WIDTH-1:0] residual,
                              logic [hsr_pkg::POS_WIDTH-1:0] row,
                              logic [hsr_pkg::POS_WIDTH-1:0] col,
                              logic last_of_run);
      residual_item_type exp_item;
      if (expected_residuals.size() == 0) begin
         $error("unexpected result: row %0d col %0d residual %0d", row, col, residual);
         errors++;
         return;
      end
      exp_item = expected_residuals.pop_front();
      if (residual !== exp_item.residual) begin
         $error("residual: expected %0d actual %0d", exp_item.residual, residual);
         errors++;
      end
      if (row !== exp_item.row) begin
         $error("out_row: expected %0d actual %0d", exp_item.row, row);
         errors++;
      end
      if (col !== exp_item.col) begin
         $error("out_col: expected %0d actual %0d", exp_item.col, col);
         errors++;
      end
      if (last_of_run !== exp_item.last_of_run) begin
         $error("last_of_run: expected %0d actual %0d", exp_item.last_of_run, last_of_run);
         errors++;
      end
   endfunction

   function void close_out();
      if (expected_residuals.size() != 0) begin
         $error("%0d expected results never arrived", expected_residuals.size());
         errors += expected_residuals.size();
      end
   endfunction
endclass

module heat_stencil_residual_core_test;
   import hsr_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int RANDOM_POINTS  = 60;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   hsr_req_if req_bus();
   hsr_rsp_if rsp_bus();

   residual_scoreboard sb;
   int unsigned idle_cycles = 0;
   int unsigned rsp_cycle   = 0;
   int unsigned rsp_mode    = 0;
   int unsigned stall_left  = 0;

   heat_stencil_residual_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Result side: check each transfer, then pick the next ready from the current stall pattern.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_result(rsp_bus.residual, rsp_bus.out_row, rsp_bus.out_col,
                         rsp_bus.last_of_run);
      end
      rsp_cycle++;
      if (rsp_cycle % 200 == 0) rsp_mode = $urandom_range(0, 3);
      case (rsp_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= 1'($urandom_range(0, 1));
         2: rsp_bus.ready <= (rsp_cycle % 8) < 5;
         default: begin
            if (stall_left != 0) begin
               stall_left--;
               rsp_bus.ready <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
               stall_left = $urandom_range(4, 20);
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function automatic logic signed [31:0] pick_value(input bit checker_mode, input bit high);
      if (checker_mode) return high ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'sh0;
         3: return -32'sd1;
         4: return $urandom_range(0, 8191) - 4096;
         default: return $urandom();
      endcase
   endfunction

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      // Row-zero points give no result but may still be in the pipeline.
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_point(input logic signed [31:0] u, input logic signed [31:0] ud);
      req_bus.valid      <= 1'b1;
      req_bus.u_value    <= u;
      req_bus.udot_value <= ud;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_point(u, ud);
   endtask

   task automatic program_grid(input bit set_w, input logic [CSR_DATA_WIDTH-1:0] w,
                               input bit set_h, input logic [CSR_DATA_WIDTH-1:0] h);
      wait_drained();
      if (set_w) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_GRID_WIDTH;
         csr_wdata <= w;
         sb.write_reg(CSR_GRID_WIDTH, w);
         @(posedge clock);
      end
      if (set_h) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_GRID_HEIGHT;
         csr_wdata <= h;
         sb.write_reg(CSR_GRID_HEIGHT, h);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Sends points in bursts; the checkerboard pattern puts opposite extremes on neighbors.
   task automatic run_phase(input int unsigned n_points, input int unsigned w_eff,
                            input bit checker_mode);
      int unsigned k;
      int unsigned burst_left;
      bit parity;
      logic signed [31:0] u;
      logic signed [31:0] ud;
      burst_left = 0;
      for (k = 0; k < n_points; k++) begin
         if (burst_left == 0) begin
            if (k != 0) begin
               req_bus.valid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
               if ($urandom_range(0, 15) == 0) wait_drained();
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 30);
         end
         parity = 1'(((k % w_eff) + (k / w_eff)) & 1);
         u  = pick_value(checker_mode, parity);
         ud = pick_value(checker_mode, !parity);
         send_point(u, ud);
         burst_left--;
      end
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int unsigned cur_w, cur_h, n, random_points, sel;
      bit checker_mode;
      sb = new();
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_GRID_WIDTH;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.u_value    <= '0;
      req_bus.udot_value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extremes on the reset-default 10x10 grid, then a few more of its rows.
      run_phase(25, GRID_RESET, 1'b1);
      run_phase(25, GRID_RESET, 1'b0);

      // Register values below the minimum clamp to 3; a lone write restarts the grid.
      program_grid(1'b1, 9'd0, 1'b1, 9'd2);
      run_phase(20, MIN_DIM, 1'b0);
      program_grid(1'b0, 9'd0, 1'b1, 9'd5);
      run_phase(15, MIN_DIM, 1'b0);
      program_grid(1'b1, 9'd3, 1'b1, 9'd3);
      run_phase(18, MIN_DIM, 1'b1);

      // A width above the maximum clamps to full-width rows; the row wraps at the maximum.
      program_grid(1'b1, 9'd511, 1'b1, 9'd3);
      run_phase(DEF_MAX_WIDTH + 6, DEF_MAX_WIDTH, 1'b1);

      program_grid(1'b1, 9'd6, 1'b1, 9'd4);
      cur_w = 6;
      cur_h = 4;
      random_points = 0;
      while (random_points < RANDOM_POINTS) begin
         sel = $urandom_range(0, 3);
         if (sel == 0 || sel == 1)
            cur_w = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 20) : $urandom_range(3, 8);
         if (sel == 0 || sel == 2) cur_h = $urandom_range(3, 5);
         if (sel != 3)
            program_grid(sel != 2, CSR_DATA_WIDTH'(cur_w), sel != 1, CSR_DATA_WIDTH'(cur_h));
         n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, cur_w * cur_h)
                                         : cur_w * cur_h * $urandom_range(1, 2);
         if (n > RANDOM_POINTS - random_points) n = RANDOM_POINTS - random_points;
         checker_mode = ($urandom_range(0, 3) == 0);
         run_phase(n, cur_w, checker_mode);
         random_points += n;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      sb.close_out();
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
